@@ hw/rtl/cptb_pkg.sv @@
// Shared widths, codes and types for the closest-point-on-triangle pipeline.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package cptb_pkg;

  localparam int COORD_BITS = 32;
  localparam int DIFF_W     = COORD_BITS + 1;        // vertex/point differences
  localparam int PROD_W     = 2 * DIFF_W;            // one coordinate product
  localparam int DOT_W      = PROD_W + 2;            // sum of three products
  localparam int LO_W       = DOT_W / 2;             // unsigned low slice of a dot
  localparam int HI_W       = DOT_W - LO_W;          // signed high slice of a dot
  localparam int XP_W       = 2 * DOT_W;             // product of two dots
  localparam int CR_W       = XP_W + 1;              // va, vb, vc
  localparam int E_W        = DOT_W + 1;             // e1, e2
  localparam int DEN_W      = CR_W + 2;              // va + vb + vc
  localparam int DV_W       = DEN_W;                 // divider operand width
  localparam int WF         = 30;                    // weight fraction bits
  localparam int W_W        = WF + 1;                // weight port width
  localparam logic [W_W-1:0] W_ONE = W_W'(1) << WF;
  localparam int DIV_LAT    = WF + 1;                // divider register stages

  typedef enum logic [2:0] {
    REG_VA   = 3'd0,
    REG_VB   = 3'd1,
    REG_AB   = 3'd2,
    REG_VC   = 3'd3,
    REG_AC   = 3'd4,
    REG_BC   = 3'd5,
    REG_FACE = 3'd6
  } region_e;

  typedef struct packed {
    logic signed [DOT_W-1:0] d1;
    logic signed [DOT_W-1:0] d2;
    logic signed [DOT_W-1:0] d3;
    logic signed [DOT_W-1:0] d4;
    logic signed [DOT_W-1:0] d5;
    logic signed [DOT_W-1:0] d6;
  } dot_t;

  typedef struct packed {
    dot_t                    dot;
    logic signed [CR_W-1:0]  va;
    logic signed [CR_W-1:0]  vb;
    logic signed [CR_W-1:0]  vc;
    logic signed [E_W-1:0]   e1;
    logic signed [E_W-1:0]   e2;
    logic signed [DEN_W-1:0] den;
  } geo_t;

  typedef struct packed {
    logic    valid;
    region_e region;
    logic    degenerate;
  } tag_t;

endpackage

@@ hw/rtl/cptb_dot.sv @@
// Edge/point differences and the six dot products d1..d6, three stages.
// Depends on cptb_pkg.
`timescale 1ns / 1ps

module cptb_dot import cptb_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] p_i [3],
  input  logic signed [COORD_BITS-1:0] a_i [3],
  input  logic signed [COORD_BITS-1:0] b_i [3],
  input  logic signed [COORD_BITS-1:0] c_i [3],
  output logic                         valid_o,
  output dot_t                         dot_o
);

  logic signed [DIFF_W-1:0] ab_q [3];
  logic signed [DIFF_W-1:0] ac_q [3];
  logic signed [DIFF_W-1:0] ap_q [3];
  logic signed [DIFF_W-1:0] bp_q [3];
  logic signed [DIFF_W-1:0] cp_q [3];
  logic signed [PROD_W-1:0] pr_q [6][3];
  dot_t                     dot_q;
  logic [2:0]               v_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ab_q[i] <= DIFF_W'(b_i[i]) - DIFF_W'(a_i[i]);
      ac_q[i] <= DIFF_W'(c_i[i]) - DIFF_W'(a_i[i]);
      ap_q[i] <= DIFF_W'(p_i[i]) - DIFF_W'(a_i[i]);
      bp_q[i] <= DIFF_W'(p_i[i]) - DIFF_W'(b_i[i]);
      cp_q[i] <= DIFF_W'(p_i[i]) - DIFF_W'(c_i[i]);
      pr_q[0][i] <= ab_q[i] * ap_q[i];
      pr_q[1][i] <= ac_q[i] * ap_q[i];
      pr_q[2][i] <= ab_q[i] * bp_q[i];
      pr_q[3][i] <= ac_q[i] * bp_q[i];
      pr_q[4][i] <= ab_q[i] * cp_q[i];
      pr_q[5][i] <= ac_q[i] * cp_q[i];
    end
    dot_q.d1 <= DOT_W'(pr_q[0][0]) + DOT_W'(pr_q[0][1]) + DOT_W'(pr_q[0][2]);
    dot_q.d2 <= DOT_W'(pr_q[1][0]) + DOT_W'(pr_q[1][1]) + DOT_W'(pr_q[1][2]);
    dot_q.d3 <= DOT_W'(pr_q[2][0]) + DOT_W'(pr_q[2][1]) + DOT_W'(pr_q[2][2]);
    dot_q.d4 <= DOT_W'(pr_q[3][0]) + DOT_W'(pr_q[3][1]) + DOT_W'(pr_q[3][2]);
    dot_q.d5 <= DOT_W'(pr_q[4][0]) + DOT_W'(pr_q[4][1]) + DOT_W'(pr_q[4][2]);
    dot_q.d6 <= DOT_W'(pr_q[5][0]) + DOT_W'(pr_q[5][1]) + DOT_W'(pr_q[5][2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  assign valid_o = v_q[2];
  assign dot_o   = dot_q;

endmodule

@@ hw/rtl/cptb_cross.sv @@
// Cross terms va, vb, vc from partial products of split 34-bit halves, edge terms and
// the face denominator, four stages. Depends on cptb_pkg.
`timescale 1ns / 1ps

module cptb_cross import cptb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  dot_t dot_i,
  output logic valid_o,
  output geo_t geo_o
);

  logic signed [DOT_W-1:0]       opx [6];
  logic signed [DOT_W-1:0]       opy [6];
  logic signed [2*HI_W-1:0]      hh_q [6];
  logic signed [HI_W+LO_W:0]     hl_q [6];
  logic signed [HI_W+LO_W:0]     lh_q [6];
  logic        [2*LO_W-1:0]      ll_q [6];
  logic signed [XP_W-1:0]        xp_q [6];
  dot_t                          dot4_q, dot5_q;
  geo_t                          g6_q, g7_q;
  logic [3:0]                    v_q;

  // pairs: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  assign opx[0] = dot_i.d1;  assign opy[0] = dot_i.d4;
  assign opx[1] = dot_i.d3;  assign opy[1] = dot_i.d2;
  assign opx[2] = dot_i.d5;  assign opy[2] = dot_i.d2;
  assign opx[3] = dot_i.d1;  assign opy[3] = dot_i.d6;
  assign opx[4] = dot_i.d3;  assign opy[4] = dot_i.d6;
  assign opx[5] = dot_i.d5;  assign opy[5] = dot_i.d4;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      hh_q[k] <= $signed(opx[k][DOT_W-1:LO_W]) * $signed(opy[k][DOT_W-1:LO_W]);
      hl_q[k] <= $signed(opx[k][DOT_W-1:LO_W]) * $signed({1'b0, opy[k][LO_W-1:0]});
      lh_q[k] <= $signed({1'b0, opx[k][LO_W-1:0]}) * $signed(opy[k][DOT_W-1:LO_W]);
      ll_q[k] <= opx[k][LO_W-1:0] * opy[k][LO_W-1:0];
      xp_q[k] <= (XP_W'(hh_q[k]) << (2 * LO_W))
               + ((XP_W'(hl_q[k]) + XP_W'(lh_q[k])) << LO_W)
               + XP_W'(ll_q[k]);
    end
    dot4_q <= dot_i;
    dot5_q <= dot4_q;
    g6_q.dot <= dot5_q;
    g6_q.vc  <= CR_W'(xp_q[0]) - CR_W'(xp_q[1]);
    g6_q.vb  <= CR_W'(xp_q[2]) - CR_W'(xp_q[3]);
    g6_q.va  <= CR_W'(xp_q[4]) - CR_W'(xp_q[5]);
    g6_q.e1  <= E_W'(dot5_q.d4) - E_W'(dot5_q.d3);
    g6_q.e2  <= E_W'(dot5_q.d5) - E_W'(dot5_q.d6);
    g6_q.den <= '0;
    g7_q.dot <= g6_q.dot;
    g7_q.va  <= g6_q.va;
    g7_q.vb  <= g6_q.vb;
    g7_q.vc  <= g6_q.vc;
    g7_q.e1  <= g6_q.e1;
    g7_q.e2  <= g6_q.e2;
    g7_q.den <= DEN_W'(g6_q.va) + DEN_W'(g6_q.vb) + DEN_W'(g6_q.vc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  assign valid_o = v_q[3];
  assign geo_o   = g7_q;

endmodule

@@ hw/rtl/cptb_div.sv @@
// Pipelined restoring divider: floor(n * 2^30 / d) clamped to [0, 1.0],
// one quotient bit per stage. Depends on cptb_pkg.
`timescale 1ns / 1ps

module cptb_div import cptb_pkg::*; (
  input  logic                   clk_i,
  input  logic signed [DV_W-1:0] num_i,
  input  logic signed [DV_W-1:0] den_i,
  output logic        [W_W-1:0]  q_o
);

  localparam int R_W = DV_W - 1;

  logic [R_W-1:0] rem_q  [WF+1];
  logic [R_W-1:0] dn_q   [WF+1];
  logic [WF-1:0]  q_q    [WF+1];
  logic           zero_q [WF+1];
  logic           one_q  [WF+1];

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= num_i[R_W-1:0];
    dn_q[0]   <= den_i[R_W-1:0];
    q_q[0]    <= '0;
    zero_q[0] <= (den_i <= 0) || (num_i <= 0);
    one_q[0]  <= num_i >= den_i;
  end

  for (genvar k = 1; k <= WF; k++) begin : g_step
    logic [R_W:0] rem2;
    logic [R_W:0] diff;
    logic         ge;
    assign rem2 = {rem_q[k-1], 1'b0};
    assign diff = rem2 - {1'b0, dn_q[k-1]};
    assign ge   = rem2 >= {1'b0, dn_q[k-1]};
    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[R_W-1:0] : rem2[R_W-1:0];
      dn_q[k]   <= dn_q[k-1];
      q_q[k]    <= {q_q[k-1][WF-2:0], ge};
      zero_q[k] <= zero_q[k-1];
      one_q[k]  <= one_q[k-1];
    end
  end

  always_comb begin
    priority if (zero_q[WF]) begin
      q_o = '0;
    end else if (one_q[WF]) begin
      q_o = W_ONE;
    end else begin
      q_o = {1'b0, q_q[WF]};
    end
  end

endmodule

@@ hw/rtl/closest_point_triangle_barycentric.sv @@
// Top level: closest point on a triangle as barycentric weights and region.
// Depends on cptb_pkg, cptb_dot, cptb_cross, cptb_div.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------
//   request  | start, busy         | query_*_i, vert_{a,b,c}_*_i (Q16.16)
//   result   | done_o (one cycle)  | weight_{a,b,c}_o, region_o, degenerate_o
//
// Fully pipelined: one request per cycle, busy stays low. A result passes
// through 3 dot-product, 4 cross-product and 1 decision stage, the 31-stage
// quotient pipeline (entry plus one stage per bit) and 1 output stage.
// Reset clears the valid bits and region/degenerate tags traveling with the
// data; the data registers are not reset. Results are strobed for one cycle
// and cannot be held off.
`timescale 1ns / 1ps

module closest_point_triangle_barycentric import cptb_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic signed [COORD_BITS-1:0] query_z_i,
  input  logic signed [COORD_BITS-1:0] vert_a_x_i,
  input  logic signed [COORD_BITS-1:0] vert_a_y_i,
  input  logic signed [COORD_BITS-1:0] vert_a_z_i,
  input  logic signed [COORD_BITS-1:0] vert_b_x_i,
  input  logic signed [COORD_BITS-1:0] vert_b_y_i,
  input  logic signed [COORD_BITS-1:0] vert_b_z_i,
  input  logic signed [COORD_BITS-1:0] vert_c_x_i,
  input  logic signed [COORD_BITS-1:0] vert_c_y_i,
  input  logic signed [COORD_BITS-1:0] vert_c_z_i,
  output logic                         done_o,
  output logic [W_W-1:0]               weight_a_o,
  output logic [W_W-1:0]               weight_b_o,
  output logic [W_W-1:0]               weight_c_o,
  output logic [2:0]                   region_o,
  output logic                         degenerate_o
);

  logic signed [COORD_BITS-1:0] p [3];
  logic signed [COORD_BITS-1:0] a [3];
  logic signed [COORD_BITS-1:0] b [3];
  logic signed [COORD_BITS-1:0] c [3];
  logic                         dot_valid, geo_valid;
  dot_t                         dot;
  geo_t                         geo;

  logic signed [DV_W-1:0] n0_d, n1_d, dd_d;
  logic signed [DV_W-1:0] n0_q, n1_q, dd_q;
  region_e                reg_d;
  logic                   deg_d;
  tag_t                   tag_q [DIV_LAT+1];
  logic [W_W-1:0]         q0, q1;
  logic [W_W:0]           qsum;
  logic [W_W-1:0]         wa_d, wb_d, wc_d;
  logic [W_W-1:0]         wa_q, wb_q, wc_q;
  logic [2:0]             reg_q;
  logic                   deg_q, done_q;

  assign busy = 1'b0;

  assign p = '{query_x_i, query_y_i, query_z_i};
  assign a = '{vert_a_x_i, vert_a_y_i, vert_a_z_i};
  assign b = '{vert_b_x_i, vert_b_y_i, vert_b_z_i};
  assign c = '{vert_c_x_i, vert_c_y_i, vert_c_z_i};

  cptb_dot u_dot (
    .clk_i, .rst_ni,
    .valid_i (start),
    .p_i     (p),
    .a_i     (a),
    .b_i     (b),
    .c_i     (c),
    .valid_o (dot_valid),
    .dot_o   (dot)
  );

  cptb_cross u_cross (
    .clk_i, .rst_ni,
    .valid_i (dot_valid),
    .dot_i   (dot),
    .valid_o (geo_valid),
    .geo_o   (geo)
  );

  // region decision, in the classic test order
  always_comb begin
    n0_d  = '0;
    n1_d  = '0;
    dd_d  = '0;
    deg_d = 1'b0;
    priority if (geo.dot.d1 <= 0 && geo.dot.d2 <= 0) begin
      reg_d = REG_VA;
    end else if (geo.dot.d3 >= 0 && geo.dot.d3 >= geo.dot.d4) begin
      reg_d = REG_VB;
    end else if (geo.vc <= 0 && geo.dot.d1 >= 0 && geo.dot.d3 <= 0) begin
      reg_d = REG_AB;
      n0_d  = DV_W'(geo.dot.d1);
      dd_d  = DV_W'(geo.dot.d1) - DV_W'(geo.dot.d3);
    end else if (geo.dot.d6 >= 0 && geo.dot.d6 >= geo.dot.d5) begin
      reg_d = REG_VC;
    end else if (geo.vb <= 0 && geo.dot.d2 >= 0 && geo.dot.d6 <= 0) begin
      reg_d = REG_AC;
      n0_d  = DV_W'(geo.dot.d2);
      dd_d  = DV_W'(geo.dot.d2) - DV_W'(geo.dot.d6);
    end else if (geo.va <= 0 && geo.e1 >= 0 && geo.e2 >= 0) begin
      reg_d = REG_BC;
      n0_d  = DV_W'(geo.e1);
      dd_d  = DV_W'(geo.e1) + DV_W'(geo.e2);
    end else if (geo.den == 0) begin
      reg_d = REG_FACE;
      deg_d = 1'b1;
    end else begin
      reg_d = REG_FACE;
      n0_d  = DV_W'(geo.vb);
      n1_d  = DV_W'(geo.vc);
      dd_d  = DV_W'(geo.den);
    end
  end

  always_ff @(posedge clk_i) begin
    n0_q <= n0_d;
    n1_q <= n1_d;
    dd_q <= dd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= DIV_LAT; j++) begin
        tag_q[j] <= '{valid: 1'b0, region: REG_VA, degenerate: 1'b0};
      end
    end else begin
      tag_q[0] <= '{valid: geo_valid, region: reg_d, degenerate: deg_d};
      for (int j = 1; j <= DIV_LAT; j++) begin
        tag_q[j] <= tag_q[j-1];
      end
    end
  end

  cptb_div u_div0 (.clk_i, .num_i(n0_q), .den_i(dd_q), .q_o(q0));
  cptb_div u_div1 (.clk_i, .num_i(n1_q), .den_i(dd_q), .q_o(q1));

  assign qsum = {1'b0, q0} + {1'b0, q1};

  always_comb begin
    wa_d = '0;
    wb_d = '0;
    wc_d = '0;
    unique case (tag_q[DIV_LAT].region)
      REG_VA: wa_d = W_ONE;
      REG_VB: wb_d = W_ONE;
      REG_VC: wc_d = W_ONE;
      REG_AB: begin
        wa_d = W_ONE - q0;
        wb_d = q0;
      end
      REG_AC: begin
        wa_d = W_ONE - q0;
        wc_d = q0;
      end
      REG_BC: begin
        wb_d = W_ONE - q0;
        wc_d = q0;
      end
      REG_FACE: begin
        if (tag_q[DIV_LAT].degenerate) begin
          wa_d = W_ONE;
        end else begin
          wa_d = (qsum >= {1'b0, W_ONE}) ? '0 : W_W'({1'b0, W_ONE} - qsum);
          wb_d = q0;
          wc_d = q1;
        end
      end
      default: begin
        wa_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    wa_q  <= wa_d;
    wb_q  <= wb_d;
    wc_q  <= wc_d;
    reg_q <= tag_q[DIV_LAT].region;
    deg_q <= tag_q[DIV_LAT].degenerate;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tag_q[DIV_LAT].valid;
    end
  end

  assign done_o       = done_q;
  assign weight_a_o   = wa_q;
  assign weight_b_o   = wb_q;
  assign weight_c_o   = wc_q;
  assign region_o     = reg_q;
  assign degenerate_o = deg_q;

endmodule

@@ tb/closest_point_triangle_barycentric_checker.sv @@
// Scoreboard for the closest-point-on-triangle block: predicts each request
// and compares it with the strobed result. Depends on cptb_pkg.
`timescale 1ns / 1ps

module closest_point_triangle_barycentric_checker import cptb_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic signed [COORD_BITS-1:0] coord_i [12],
  input  logic                         done_i,
  input  logic [W_W-1:0]               weight_a_i,
  input  logic [W_W-1:0]               weight_b_i,
  input  logic [W_W-1:0]               weight_c_i,
  input  logic [2:0]                   region_i,
  input  logic                         degenerate_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef logic signed [255:0] big_t;

  typedef struct {
    logic [W_W-1:0] wa;
    logic [W_W-1:0] wb;
    logic [W_W-1:0] wc;
    region_e        region;
    logic           degenerate;
  } closest_t;

  closest_t closest_q[$];

  function automatic logic [W_W-1:0] quotient(big_t n, big_t d);
    logic [255:0] nu, du;
    if (d <= 0 || n <= 0) return '0;
    if (n >= d) return W_ONE;
    nu = n;
    du = d;
    return W_W'((nu << WF) / du);
  endfunction

  function automatic big_t dot(big_t u[3], big_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic closest_t closest_point(logic signed [COORD_BITS-1:0] c[12]);
    closest_t r;
    big_t ab[3], ac[3], ap[3], bp[3], cp[3];
    big_t d1, d2, d3, d4, d5, d6, va, vb, vc, den, e1, e2;
    logic [W_W-1:0] v, w;
    for (int i = 0; i < 3; i++) begin
      ab[i] = big_t'(c[6+i]) - big_t'(c[3+i]);
      ac[i] = big_t'(c[9+i]) - big_t'(c[3+i]);
      ap[i] = big_t'(c[i]) - big_t'(c[3+i]);
      bp[i] = big_t'(c[i]) - big_t'(c[6+i]);
      cp[i] = big_t'(c[i]) - big_t'(c[9+i]);
    end
    r.degenerate = 1'b0;
    d1 = dot(ab, ap);
    d2 = dot(ac, ap);
    if (d1 <= 0 && d2 <= 0) begin
      r.wa = W_ONE; r.wb = '0; r.wc = '0; r.region = REG_VA;
      return r;
    end
    d3 = dot(ab, bp);
    d4 = dot(ac, bp);
    if (d3 >= 0 && d3 >= d4) begin
      r.wa = '0; r.wb = W_ONE; r.wc = '0; r.region = REG_VB;
      return r;
    end
    vc = d1 * d4 - d3 * d2;
    if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      v = quotient(d1, d1 - d3);
      r.wa = W_ONE - v; r.wb = v; r.wc = '0; r.region = REG_AB;
      return r;
    end
    d5 = dot(ab, cp);
    d6 = dot(ac, cp);
    if (d6 >= 0 && d6 >= d5) begin
      r.wa = '0; r.wb = '0; r.wc = W_ONE; r.region = REG_VC;
      return r;
    end
    vb = d5 * d2 - d1 * d6;
    if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      w = quotient(d2, d2 - d6);
      r.wa = W_ONE - w; r.wb = '0; r.wc = w; r.region = REG_AC;
      return r;
    end
    va = d3 * d6 - d5 * d4;
    e1 = d4 - d3;
    e2 = d5 - d6;
    if (va <= 0 && e1 >= 0 && e2 >= 0) begin
      w = quotient(e1, e1 + e2);
      r.wa = '0; r.wb = W_ONE - w; r.wc = w; r.region = REG_BC;
      return r;
    end
    den = va + vb + vc;
    r.region = REG_FACE;
    if (den == 0) begin
      r.wa = W_ONE; r.wb = '0; r.wc = '0; r.degenerate = 1'b1;
      return r;
    end
    v = quotient(vb, den);
    w = quotient(vc, den);
    r.wa = (32'(v) + 32'(w) >= 32'(W_ONE)) ? '0 : W_ONE - v - w;
    r.wb = v;
    r.wc = w;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  assign pending_o = closest_q.size();

  always @(posedge clk_i) begin
    closest_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
    end else begin
      if (done_i) begin
        if (closest_q.size() == 0) begin
          report_mismatch("result with no request waiting", 1, 0);
        end else begin
          want = closest_q.pop_front();
          if (weight_a_i !== want.wa) report_mismatch("weight_a", weight_a_i, want.wa);
          if (weight_b_i !== want.wb) report_mismatch("weight_b", weight_b_i, want.wb);
          if (weight_c_i !== want.wc) report_mismatch("weight_c", weight_c_i, want.wc);
          if (region_i !== want.region) report_mismatch("region", region_i, want.region);
          if (degenerate_i !== want.degenerate)
            report_mismatch("degenerate", degenerate_i, want.degenerate);
        end
      end
      if (start_i && !busy_i) closest_q = {closest_q, closest_point(coord_i)};
    end
  end

endmodule

@@ tb/closest_point_triangle_barycentric_tb.sv @@
// Top of the closest-point-on-triangle testbench: clock, reset, requests.
// Depends on cptb_pkg, the block and closest_point_triangle_barycentric_checker.
`timescale 1ns / 1ps

module closest_point_triangle_barycentric_tb import cptb_pkg::*;;

  localparam int N_RANDOM  = 1030;
  localparam int CYC_LIMIT = 400000;
  localparam int ONE       = 65536;

  logic clk_i, rst_ni, start, busy, done_o, degenerate_o;
  logic signed [COORD_BITS-1:0] coord [12];
  logic [W_W-1:0] weight_a_o, weight_b_o, weight_c_o;
  logic [2:0] region_o;
  int fail_count, pending, cycles;

  closest_point_triangle_barycentric DUT (
    .clk_i, .rst_ni, .start, .busy,
    .query_x_i(coord[0]), .query_y_i(coord[1]), .query_z_i(coord[2]),
    .vert_a_x_i(coord[3]), .vert_a_y_i(coord[4]), .vert_a_z_i(coord[5]),
    .vert_b_x_i(coord[6]), .vert_b_y_i(coord[7]), .vert_b_z_i(coord[8]),
    .vert_c_x_i(coord[9]), .vert_c_y_i(coord[10]), .vert_c_z_i(coord[11]),
    .done_o, .weight_a_o, .weight_b_o, .weight_c_o, .region_o, .degenerate_o
  );

  closest_point_triangle_barycentric_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .coord_i(coord),
    .done_i(done_o), .weight_a_i(weight_a_o), .weight_b_i(weight_b_o),
    .weight_c_i(weight_c_o), .region_i(region_o), .degenerate_i(degenerate_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("closest_point_triangle_barycentric test failed");
      $finish;
    end
  end

  // Drive one request at the falling edge and hold it until accepted.
  task automatic send_request(int p[12]);
    @(negedge clk_i);
    for (int i = 0; i < 12; i++) coord[i] <= p[i];
    start <= 1'b1;
    #1;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic idle_burst(int n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Query point p against triangle a, b, c (coordinates already scaled).
  task automatic send_tri(int px, int py, int pz, int ax, int ay, int az,
                          int bx, int by, int bz, int cx, int cy, int cz);
    int p[12];
    p = '{px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
    send_request(p);
  endtask

  function automatic int near_coord(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  initial begin
    int p[12];
    int span, kind;
    rst_ni = 1'b0;
    start  = 1'b0;
    for (int i = 0; i < 12; i++) coord[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Unit right triangle in the z = 0 plane, each region once.
    send_tri(-ONE, -ONE, 0,      0, 0, 0,  ONE, 0, 0,  0, ONE, 0);
    send_tri(2*ONE, -ONE, ONE,   0, 0, 0,  ONE, 0, 0,  0, ONE, 0);
    send_tri(ONE/3, -ONE, 0,     0, 0, 0,  ONE, 0, 0,  0, ONE, 0);
    send_tri(-ONE, 2*ONE, 0,     0, 0, 0,  ONE, 0, 0,  0, ONE, 0);
    send_tri(-ONE, ONE/7, 5,     0, 0, 0,  ONE, 0, 0,  0, ONE, 0);
    send_tri(ONE, ONE, -ONE,     0, 0, 0,  ONE, 0, 0,  0, ONE, 0);
    send_tri(ONE/5, ONE/3, ONE,  0, 0, 0,  ONE, 0, 0,  0, ONE, 0);
    // collinear vertices, coincident vertices, zero-length edges
    send_tri(ONE, ONE, 0,        0, 0, 0,  ONE, 0, 0,  2*ONE, 0, 0);
    send_tri(ONE/2, ONE, 0,      0, 0, 0,  2*ONE, 0, 0,  ONE, 0, 0);
    send_tri(ONE, ONE, ONE,      0, 0, 0,  0, 0, 0,  0, ONE, 0);
    send_tri(ONE, ONE, ONE,      0, 0, 0,  ONE, 0, 0,  0, 0, 0);
    send_tri(ONE, ONE, ONE,      ONE, 0, 0,  0, 0, 0,  0, 0, 0);
    send_tri(0, 0, 0,            0, 0, 0,  0, 0, 0,  0, 0, 0);
    send_tri(5, 5, 5,            5, 5, 5,  5, 5, 5,  5, 5, 5);
    // coordinate extremes
    for (int i = 0; i < 12; i++) p[i] = 32'h7fffffff;
    send_request(p);
    for (int i = 0; i < 12; i++) p[i] = 32'h80000000;
    send_request(p);
    for (int i = 0; i < 12; i++) p[i] = (i < 3) ? 32'h7fffffff : 32'h80000000;
    send_request(p);
    for (int i = 0; i < 12; i++) p[i] = (i < 3) ? 32'h80000000 : 32'h7fffffff;
    send_request(p);
    p = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0,
          32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff};
    send_request(p);
    p = '{0, 0, 0, 32'h80000000, 32'h80000000, 0, 32'h7fffffff, 32'h80000000, 0,
          32'h80000000, 32'h7fffffff, 0};
    send_request(p);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // drain the pipeline completely once
        @(negedge clk_i);
        start <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      kind = $urandom_range(9);
      span = ($urandom_range(3) == 0) ? 1000 : (1 << $urandom_range(30, 12));
      for (int i = 0; i < 12; i++)
        p[i] = (kind < 2) ? $urandom() : near_coord(span);
      if (kind == 2) begin
        // repeated vertex
        for (int i = 0; i < 3; i++) p[3 + 3*$urandom_range(1, 2) + i] = p[3 + i];
      end else if (kind == 3) begin
        // collinear: c = a + 2(b - a)
        for (int i = 0; i < 3; i++) p[9+i] = 2 * p[6+i] - p[3+i];
      end else if (kind == 4) begin
        for (int i = 0; i < 12; i++) p[i] = $urandom_range(1) ? p[i] : 32'h80000000;
      end
      send_request(p);
      if (n < N_RANDOM - 150 && $urandom_range(3) == 0) idle_burst($urandom_range(1, 18));
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("closest_point_triangle_barycentric test passed");
    end else begin
      $display("closest_point_triangle_barycentric test failed");
    end
    $finish;
  end

endmodule
